// ===== design/emb_pkg.sv =====
`timescale 1ns / 1ps
package emb_pkg;

  // Action codes of an input word.
  localparam logic [1:0] ACT_MOVE  = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAP_COLS    = 3'd0;
  localparam logic [2:0] REG_MAP_ROWS    = 3'd1;
  localparam logic [2:0] REG_OVERLAY_ON  = 3'd2;
  localparam logic [2:0] REG_OPACITY     = 3'd3;
  localparam logic [2:0] REG_SCREEN_COLS = 3'd4;
  localparam logic [2:0] REG_SCREEN_ROWS = 3'd5;

  // Headings.
  localparam logic [1:0] HD_N = 2'd0;
  localparam logic [1:0] HD_E = 2'd1;
  localparam logic [1:0] HD_S = 2'd2;
  localparam logic [1:0] HD_W = 2'd3;

  // Cell and marker colors.
  localparam logic [31:0] COL_UNEXP = 32'h8000_0000;
  localparam logic [31:0] COL_PARTY = 32'hFF00_FF00;
  localparam logic [31:0] COL_SEEN  = 32'hC040_4040;
  localparam logic [31:0] COL_MARK  = 32'hFFFF_FF00;

  localparam logic [8:0] OPACITY_MAX = 9'd256;
  localparam int         OVL_MARGIN  = 8;

  // Map size width (holds up to 64) and divider widths.
  localparam int MAP_W = 7;
  localparam int DVD_W = 13;
  localparam int DVS_W = 10;

  typedef enum logic [1:0] {
    DIV_CS = 2'd0,
    DIV_X  = 2'd1,
    DIV_Y  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic [5:0]  map_cols;
    logic [5:0]  map_rows;
    logic        overlay_on;
    logic [8:0]  opacity_q8;
    logic [11:0] screen_cols;
    logic [11:0] screen_rows;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_take;
    logic     mem_rd;
    logic     calc;
    logic     load_out;
    logic     mark;
    logic     clear;
    logic     cnt_zero;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       div_done;
    logic       mark_last;
    logic       clr_last;
    logic       out_full;
  } sts_t;

  // Map size clamped to the range 1 .. limit.
  function automatic logic [MAP_W-1:0] eff_size(input logic [5:0] v,
                                                input logic [MAP_W-1:0] limit);
    logic [MAP_W-1:0] r;
    r = {1'b0, v};
    if (v == 6'd0) r = MAP_W'(1);
    else if (r > limit) r = limit;
    return r;
  endfunction

endpackage

// ===== design/emb_div.sv =====
`timescale 1ns / 1ps
module emb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [emb_pkg::DVD_W-1:0] dividend,
  input  logic [emb_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [emb_pkg::DVD_W-1:0] quotient
);
  import emb_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [3:0]       cnt;
  logic             busy;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;

  // One quotient bit per cycle, restoring.
  assign shifted = {rem, quotient[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (shifted >= {1'b0, dvs}) begin
        rem      <= trial[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/emb_ctrl.sv =====
`timescale 1ns / 1ps
module emb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  emb_pkg::sts_t sts,
  output emb_pkg::cmd_t cmd
);
  import emb_pkg::*;

  typedef enum logic [11:0] {
    S_CLR  = 12'b0000_0000_0001,
    S_IDLE = 12'b0000_0000_0010,
    S_DISP = 12'b0000_0000_0100,
    S_MARK = 12'b0000_0000_1000,
    S_DCS  = 12'b0000_0001_0000,
    S_DX0  = 12'b0000_0010_0000,
    S_DX   = 12'b0000_0100_0000,
    S_DY0  = 12'b0000_1000_0000,
    S_DY   = 12'b0001_0000_0000,
    S_RD   = 12'b0010_0000_0000,
    S_CALC = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of words and commands to the datapath.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_CS;
    case (state)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          cmd.cnt_zero = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.action)
          ACT_MOVE:  state_next = S_MARK;
          ACT_CLEAR: state_next = S_CLR;
          ACT_PIXEL: begin
            cmd.div_start = 1'b1;
            state_next    = S_DCS;
          end
          default:   state_next = S_IDLE;
        endcase
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          cmd.cnt_zero = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DCS: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_DX0;
        end
      end
      S_DX0: begin
        cmd.div_sel   = DIV_X;
        cmd.div_start = 1'b1;
        state_next    = S_DX;
      end
      S_DX: begin
        cmd.div_sel = DIV_X;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_DY0;
        end
      end
      S_DY0: begin
        cmd.div_sel   = DIV_Y;
        cmd.div_start = 1'b1;
        state_next    = S_DY;
      end
      S_DY: begin
        cmd.div_sel = DIV_Y;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule

// ===== design/emb_dp.sv =====
`timescale 1ns / 1ps
module emb_dp #(
  parameter int MAX_MAP      = 32,
  parameter int OVERLAY_SIZE = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  emb_pkg::cfg_t cfg,
  input  emb_pkg::cmd_t cmd,
  output emb_pkg::sts_t sts,
  input  logic [1:0]    action,
  input  logic [4:0]    party_col,
  input  logic [4:0]    party_row,
  input  logic [1:0]    party_heading,
  input  logic [11:0]   pixel_col,
  input  logic [11:0]   pixel_row,
  input  logic [31:0]   backdrop,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [31:0]   pixel_out,
  output logic          touched
);
  import emb_pkg::*;

  localparam int DEPTH = MAX_MAP * MAX_MAP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam logic signed [13:0] OX_OFF = 14'(OVERLAY_SIZE + OVL_MARGIN);

  logic mem [DEPTH];
  logic rbit;

  logic [1:0]       act_q;
  logic [4:0]       party_col_reg;
  logic [4:0]       party_row_reg;
  logic [1:0]       heading_reg;
  logic [11:0]      x_q;
  logic [11:0]      y_q;
  logic [31:0]      bg_q;
  logic [CNTW-1:0]  cnt;
  logic [2:0]       mk;
  logic [DVS_W-1:0] cs_q;
  logic [DVD_W-1:0] mx_q;
  logic [DVD_W-1:0] my_q;
  logic             ov_q;
  logic             hit_q;
  logic [8:0]       a_q;
  logic [23:0]      fg_q;

  logic [MAP_W-1:0] w;
  logic [MAP_W-1:0] h;
  logic             gate;
  logic signed [13:0] ox;
  logic signed [13:0] dxs;
  logic             x_ge;
  logic             y_ge;
  logic [11:0]      dy12;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             div_done;
  logic [DVD_W-1:0] quo;

  assign w    = eff_size(cfg.map_cols, MAP_W'(MAX_MAP));
  assign h    = eff_size(cfg.map_rows, MAP_W'(MAX_MAP));
  assign gate = cfg.overlay_on && (x_q < cfg.screen_cols) && (y_q < cfg.screen_rows);

  // Overlay origin and offsets into it.
  assign ox   = $signed({2'b00, cfg.screen_cols}) - OX_OFF;
  assign dxs  = $signed({2'b00, x_q}) - ox;
  assign x_ge = ($signed({2'b00, x_q}) >= ox);
  assign y_ge = (y_q >= 12'(OVL_MARGIN));
  assign dy12 = y_q - 12'(OVL_MARGIN);

  // Divider operand selection.
  always_comb begin
    case (cmd.div_sel)
      DIV_CS: begin
        dvd = DVD_W'(OVERLAY_SIZE);
        dvs = DVS_W'(w);
      end
      DIV_X: begin
        dvd = x_ge ? dxs[DVD_W-1:0] : '0;
        dvs = cs_q;
      end
      DIV_Y: begin
        dvd = y_ge ? {1'b0, dy12} : '0;
        dvs = cs_q;
      end
      default: begin
        dvd = '0;
        dvs = DVS_W'(1);
      end
    endcase
  end

  emb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // Input capture and party state.
  always_ff @(posedge clk) begin
    if (rst) begin
      party_col_reg <= '0;
      party_row_reg <= '0;
      heading_reg   <= '0;
    end else if (cmd.capture && action == ACT_MOVE) begin
      party_col_reg <= party_col;
      party_row_reg <= party_row;
      heading_reg   <= party_heading;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      x_q   <= pixel_col;
      y_q   <= pixel_row;
      bg_q  <= backdrop;
    end
  end

  // Sweep and mark counters.
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_zero) begin
      cnt <= '0;
      mk  <= '0;
    end else begin
      if (cmd.clear) cnt <= cnt + CNTW'(1);
      if (cmd.mark)  mk  <= mk + 3'd1;
    end
  end

  // Cell picked by the mark step: center, left, right, up, down.
  logic [MAP_W-1:0] pc7;
  logic [MAP_W-1:0] pr7;
  logic [MAP_W-1:0] tc;
  logic [MAP_W-1:0] tr;
  logic             m_ok;
  logic [13:0]      wa_full;

  assign pc7 = {2'b00, party_col_reg};
  assign pr7 = {2'b00, party_row_reg};

  always_comb begin
    tc   = pc7;
    tr   = pr7;
    m_ok = 1'b1;
    case (mk)
      3'd1: begin
        tc   = pc7 - MAP_W'(1);
        m_ok = (pc7 != '0);
      end
      3'd2: begin
        tc   = pc7 + MAP_W'(1);
        m_ok = (pc7 < w - MAP_W'(1));
      end
      3'd3: begin
        tr   = pr7 - MAP_W'(1);
        m_ok = (pr7 != '0);
      end
      3'd4: begin
        tr   = pr7 + MAP_W'(1);
        m_ok = (pr7 < h - MAP_W'(1));
      end
      default: m_ok = 1'b1;
    endcase
    m_ok = m_ok && (tc < w) && (tr < h);
  end

  assign wa_full = 14'(tr) * 14'(MAX_MAP) + 14'(tc);

  // Explored bitmap.
  logic [13:0] ra_full;
  assign ra_full = 14'(my_q[MAP_W-1:0]) * 14'(MAX_MAP) + 14'(mx_q[MAP_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[cnt[AW-1:0]] <= 1'b0;
    end else if (cmd.mark && m_ok) begin
      mem[wa_full[AW-1:0]] <= 1'b1;
    end
    if (cmd.mem_rd) begin
      rbit <= mem[ra_full[AW-1:0]];
    end
  end

  // Quotient capture.
  always_ff @(posedge clk) begin
    if (div_done && cmd.div_take) begin
      case (cmd.div_sel)
        DIV_CS:  cs_q <= (quo == '0) ? DVS_W'(1) : quo[DVS_W-1:0];
        DIV_X:   mx_q <= quo;
        DIV_Y:   my_q <= quo;
        default: cs_q <= cs_q;
      endcase
    end
  end

  // Marker position one cell ahead of the party cell center.
  logic [14:0]        pcs;
  logic [14:0]        prs;
  logic signed [17:0] csx;
  logic signed [17:0] half;
  logic signed [17:0] ax;
  logic signed [17:0] ay;
  logic signed [17:0] stx;
  logic signed [17:0] sty;

  assign pcs  = 15'(party_col_reg) * 15'(cs_q);
  assign prs  = 15'(party_row_reg) * 15'(cs_q);
  assign csx  = $signed({8'b0, cs_q});
  assign half = $signed({9'b0, cs_q[DVS_W-1:1]});
  assign stx  = (heading_reg == HD_E) ? csx : (heading_reg == HD_W) ? -csx : 18'sd0;
  assign sty  = (heading_reg == HD_S) ? csx : (heading_reg == HD_N) ? -csx : 18'sd0;
  assign ax   = 18'(ox) + $signed({3'b000, pcs}) + half + stx;
  assign ay   = 18'(OVL_MARGIN) + $signed({3'b000, prs}) + half + sty;

  // Cell color and blend weight.
  logic        in_ov;
  logic [31:0] color;
  logic [8:0]  op;
  logic [16:0] v;
  logic [16:0] vr;

  assign in_ov = gate && x_ge && y_ge && (mx_q < DVD_W'(w)) && (my_q < DVD_W'(h));

  always_comb begin
    if (!rbit) color = COL_UNEXP;
    else if (mx_q == DVD_W'(party_col_reg) && my_q == DVD_W'(party_row_reg)) color = COL_PARTY;
    else color = COL_SEEN;
  end

  assign op = (cfg.opacity_q8 > OPACITY_MAX) ? OPACITY_MAX : cfg.opacity_q8;
  assign v  = 17'(color[31:24]) * 17'(op);
  // Divide by 255: exact for values below 65535.
  assign vr = v + (v >> 8) + 17'd1;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      ov_q  <= in_ov;
      hit_q <= gate && ($signed({6'b0, x_q}) == ax) && ($signed({6'b0, y_q}) == ay);
      a_q   <= vr[16:8];
      fg_q  <= color[23:0];
    end
  end

  // Channel blend.
  logic [8:0]  na;
  logic [16:0] ch0;
  logic [16:0] ch1;
  logic [16:0] ch2;
  logic [31:0] blend;

  assign na  = OPACITY_MAX - a_q;
  assign ch0 = 17'(fg_q[7:0])   * 17'(a_q) + 17'(bg_q[7:0])   * 17'(na);
  assign ch1 = 17'(fg_q[15:8])  * 17'(a_q) + 17'(bg_q[15:8])  * 17'(na);
  assign ch2 = 17'(fg_q[23:16]) * 17'(a_q) + 17'(bg_q[23:16]) * 17'(na);
  assign blend = {8'hFF, ch2[15:8], ch1[15:8], ch0[15:8]};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_out <= hit_q ? COL_MARK : (ov_q ? blend : bg_q);
      touched   <= hit_q | ov_q;
    end
  end

  assign sts.action    = act_q;
  assign sts.div_done  = div_done;
  assign sts.mark_last = (mk == 3'd4);
  assign sts.clr_last  = (cnt == CNTW'(DEPTH - 1));
  assign sts.out_full  = out_valid && !out_ready;

endmodule

// ===== design/explored_map_overlay_blender.sv =====
`timescale 1ns / 1ps
// A pixel word passes through three runs of the shared serial divider (cell size, column,
// row), a bitmap read and a blend before its result is loaded; in_ready rises again
// together with out_valid. A move word marks the party cell and those of its four
// neighbours inside the map; a clear word sweeps the bitmap clear. Throughput is one word
// at a time; a result not yet taken holds the next pixel word. Reset is synchronous; after
// it the bitmap is swept clear before in_ready rises; configuration writes are taken meanwhile.
module explored_map_overlay_blender #(
  parameter int MAX_MAP      = 32,
  parameter int OVERLAY_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [4:0]  party_col,
  input  logic [4:0]  party_row,
  input  logic [1:0]  party_heading,
  input  logic [11:0] pixel_col,
  input  logic [11:0] pixel_row,
  input  logic [31:0] backdrop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_out,
  output logic        touched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import emb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_cols    <= 6'd32;
      cfg.map_rows    <= 6'd32;
      cfg.overlay_on  <= 1'b1;
      cfg.opacity_q8  <= 9'd154;
      cfg.screen_cols <= 12'd320;
      cfg.screen_rows <= 12'd200;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_COLS:    cfg.map_cols    <= cfg_data[5:0];
        REG_MAP_ROWS:    cfg.map_rows    <= cfg_data[5:0];
        REG_OVERLAY_ON:  cfg.overlay_on  <= cfg_data[0];
        REG_OPACITY:     cfg.opacity_q8  <= cfg_data[8:0];
        REG_SCREEN_COLS: cfg.screen_cols <= cfg_data;
        REG_SCREEN_ROWS: cfg.screen_rows <= cfg_data;
        default:         cfg.map_cols    <= cfg.map_cols;
      endcase
    end
  end

  emb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  emb_dp #(
    .MAX_MAP      (MAX_MAP),
    .OVERLAY_SIZE (OVERLAY_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .party_col     (party_col),
    .party_row     (party_row),
    .party_heading (party_heading),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .backdrop      (backdrop),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .pixel_out     (pixel_out),
    .touched       (touched)
  );

  // A touched pixel always carries an opaque alpha byte.
  a_touched_opaque: assert property (@(posedge clk) disable iff (rst)
    out_valid && touched |-> pixel_out[31:24] == 8'hFF)
    else $error("touched pixel without opaque alpha");

  // With the overlay off nothing is drawn.
  a_off_untouched: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cfg.overlay_on |-> !touched)
    else $error("pixel touched while overlay is off");

  // An accepted word always keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted back to back");

endmodule
